>>> sv/txcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by text_console_writer_top.
package txcw_pkg;

    // command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE    = 8'd10;
    localparam logic [7:0] SPACE_CODE      = 8'd32;
    localparam logic [7:0] RESET_ATTRIBUTE = 8'h07;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } txcw_state_t;

    // first member is the most significant
    typedef struct packed {
        logic [7:0] read_attribute;
        logic [7:0] read_char;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } txcw_result_t;

endpackage

>>> sv/text_console_writer_top.sv
// Text console writer: cell store, cursor, scroll and clear sequencing.
// Depends on txcw_pkg.
//
// A character-cell console of ROWS x COLUMNS 16-bit cells (character in the low byte,
// attribute in the high byte) held in one synchronous memory with a registered read.
// Every transaction on the slave side produces exactly one result on the master side
// carrying the cursor after the command and, for a read, the addressed cell. A put
// that moves the cursor past the last row scrolls the screen through the memory's
// single write port: one copy per cycle, then the bottom row blanked. A clear writes
// every cell once. After reset the memory is filled with blanks in the reset
// attribute, during which no command is taken; attribute writes are taken at any
// time. A waiting result does not stop the next command from being accepted.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] command, [9:2] char_code, [20:10] cell_index, [23:21] zero
    input  logic [txcw_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [19:12] read_char,
    // [27:20] read_attribute, [31:28] zero
    output logic [txcw_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [7:0]                     cfg_data
);
    import txcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int SCROLL_LEN = COLUMNS * (ROWS - 1);
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [CNT_W-1:0] PTR_LAST  = CNT_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0] PTR_SCRL  = CNT_W'(SCROLL_LEN);
    localparam logic [15:0]      INIT_CELL = {RESET_ATTRIBUTE, SPACE_CODE};

    // input fields
    logic [1:0]  in_command;
    logic [7:0]  in_char_code;
    logic [10:0] in_cell_index;
    assign in_command    = s_tdata[1:0];
    assign in_char_code  = s_tdata[9:2];
    assign in_cell_index = s_tdata[20:10];

    txcw_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [7:0]         attr_reg;
    logic [1:0]         cmd_reg, cmd_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               out_valid_reg, out_valid_next;
    txcw_result_t       out_data_reg, out_data_next;
    logic [15:0]        rd_data_reg;

    logic [15:0]        cells_mem [CELL_COUNT];
    logic               mem_we, mem_re;
    logic [CELL_W-1:0]  mem_waddr, mem_raddr;
    logic [15:0]        mem_wdata;

    logic               accept;
    logic               out_free;
    logic [CELL_W-1:0]  put_addr;
    logic [15:0]        blank_cell;

    assign accept     = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign put_addr   = CELL_W'(CELL_W'(row_reg) * CELL_W'(COLUMNS) + CELL_W'(col_reg));
    assign blank_cell = {attr_reg, SPACE_CODE};

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cmd_next       = cmd_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == PTR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = in_command;
                    rd_ok_next = 32'(in_cell_index) < 32'(CELL_COUNT);
                    state_next = ST_DONE;
                    ptr_next   = '0;
                    unique case (in_command)
                        CMD_PUT:
                        begin
                            if (in_char_code != NEWLINE_CODE && col_reg != COL_LAST)
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            else
                            begin
                                col_next = '0;
                                if (row_reg == ROW_LAST)
                                begin
                                    state_next = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = ST_BLANK;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // ptr stays at the first bottom-row cell for the blanking pass
                if (ptr_reg == PTR_SCRL)
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_BLANK:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == PTR_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.cursor_col = 7'(col_reg);
                    out_data_next.cursor_row = 5'(row_reg);
                    if (cmd_reg == CMD_READ && rd_ok_reg)
                    begin
                        out_data_next.read_char      = rd_data_reg[7:0];
                        out_data_next.read_attribute = rd_data_reg[15:8];
                    end
                    else
                    begin
                        out_data_next.read_char      = '0;
                        out_data_next.read_attribute = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake outputs
    always_comb
    begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = put_addr;
        mem_raddr = CELL_W'(in_cell_index);
        mem_wdata = {attr_reg, in_char_code};
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = CELL_W'(ptr_reg);
                mem_wdata = INIT_CELL;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                mem_we   = accept && in_command == CMD_PUT && in_char_code != NEWLINE_CODE;
                mem_re   = accept && in_command == CMD_READ &&
                           32'(in_cell_index) < 32'(CELL_COUNT);
            end
            ST_SCROLL:
            begin
                // read runs one row and one cell ahead of the write, so the two never meet
                mem_re    = ptr_reg != PTR_SCRL;
                mem_raddr = CELL_W'(ptr_reg + CNT_W'(COLUMNS));
                mem_we    = ptr_reg != '0;
                mem_waddr = CELL_W'(ptr_reg - 1'b1);
                mem_wdata = rd_data_reg;
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = CELL_W'(ptr_reg);
                mem_wdata = blank_cell;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(OUT_DATA_W - $bits(txcw_result_t))'(0), out_data_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cells_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ptr_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= RESET_ATTRIBUTE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        rd_ok_reg    <= rd_ok_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS && 32'(row_reg) < ROWS)
        else $error("cursor outside the screen");

    a_scroll_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCROLL |-> ptr_reg <= PTR_SCRL)
        else $error("scroll pointer overran the copy range");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("read and write hit the same cell");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("command engine did not leave idle after a transaction");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion state");
`endif

endmodule
